// ----- hw/rtl/uvsg_pkg.sv -----
`timescale 1ns / 1ps

package uvsg_pkg;

  // Largest slice count the block supports.
  localparam int unsigned MAX_SLICES = 128;

  // Fixed-point constants of the sine unit (Q30).
  localparam logic [30:0] Q30_ONE     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Pipeline depth of one sine lane, from quadrant/remainder to magnitude.
  localparam int unsigned SINE_LAT = 21;

  // Taylor series divisors 110, 72, 42, 20, 6 split into a shift and an odd factor.
  // Element k belongs to Horner step k.
  localparam logic [4:0][1:0] SER_SHIFT = {2'd1, 2'd2, 2'd1, 2'd3, 2'd1};
  localparam logic [4:0][5:0] SER_ODD   = {6'd3, 6'd5, 6'd21, 6'd9, 6'd55};
  localparam logic [4:0][37:0] SER_RECIP = {
    38'((64'd1 << 38) / 64'd3),
    38'((64'd1 << 38) / 64'd5),
    38'((64'd1 << 38) / 64'd21),
    38'((64'd1 << 38) / 64'd9),
    38'((64'd1 << 38) / 64'd55)
  };

  // Slice-count dependent constants shared by all sine lanes.
  typedef struct packed {
    logic [7:0]  n;      // clamped slice count
    logic [30:0] recip;  // floor(2^30 / n)
    logic [30:0] hq;     // floor(HALF_PI_Q30 / n)
    logic [6:0]  hr;     // HALF_PI_Q30 mod n
  } sine_cfg_t;

endpackage

// ----- hw/rtl/uvsg_sine.sv -----
`timescale 1ns / 1ps

module uvsg_sine (
  input  logic                clk_i,
  input  logic                en_i,
  input  uvsg_pkg::sine_cfg_t cfg_i,
  input  logic [1:0]          quad_i,
  input  logic [6:0]          rem_i,
  output logic [30:0]         mag_o,
  output logic                neg_o
);
  import uvsg_pkg::*;

  // Stage a: split rem*HALF_PI/n into rem*floor(H/n) plus rem*(H mod n)/n.
  logic [13:0] a_a_q;
  logic [30:0] b_a_q;
  logic        odd_a_q, neg_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_a_q   <= 14'({7'd0, rem_i} * {7'd0, cfg_i.hr});
      b_a_q   <= 31'(38'(rem_i) * 38'(cfg_i.hq));
      odd_a_q <= quad_i[0];
      neg_a_q <= quad_i[1];
    end
  end

  // Stage b: quotient estimate of the small remainder term by reciprocal.
  logic [44:0] prod_b;
  logic [7:0]  qe_b_q;
  logic [13:0] a_b_q;
  logic [30:0] b_b_q;
  logic        odd_b_q, neg_b_q;

  assign prod_b = 45'(a_a_q) * 45'(cfg_i.recip);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qe_b_q  <= prod_b[37:30];
      a_b_q   <= a_a_q;
      b_b_q   <= b_a_q;
      odd_b_q <= odd_a_q;
      neg_b_q <= neg_a_q;
    end
  end

  // Stage c: the estimate is at most one low, so one compare fixes it.
  logic [15:0] rem_c;
  logic [7:0]  qa_c_q;
  logic [30:0] b_c_q;
  logic        odd_c_q, neg_c_q;

  assign rem_c = 16'(a_b_q) - 16'(qe_b_q) * 16'(cfg_i.n);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qa_c_q  <= (rem_c >= 16'(cfg_i.n)) ? qe_b_q + 8'd1 : qe_b_q;
      b_c_q   <= b_b_q;
      odd_c_q <= odd_b_q;
      neg_c_q <= neg_b_q;
    end
  end

  // Stage d: reduced angle, mirrored in odd quadrants.
  logic [30:0] sum_d;
  logic [30:0] x_d_q;
  logic        neg_d_q;

  assign sum_d = b_c_q + 31'(qa_c_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_d_q   <= odd_c_q ? HALF_PI_Q30 - sum_d : sum_d;
      neg_d_q <= neg_c_q;
    end
  end

  // Stage e: square of the angle.
  logic [61:0] sq_e;
  logic [31:0] x2_e_q;
  logic [30:0] x_e_q;
  logic        neg_e_q;

  assign sq_e = 62'(x_d_q) * 62'(x_d_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_e_q  <= sq_e[61:30];
      x_e_q   <= x_d_q;
      neg_e_q <= neg_d_q;
    end
  end

  // Horner steps, three stages each: multiply, reciprocal multiply, correct.
  logic [30:0] it_t_in   [5];
  logic [30:0] it_x_in   [5];
  logic [31:0] it_x2_in  [5];
  logic        it_neg_in [5];

  logic [31:0] it1_a_q   [5];
  logic [30:0] it1_x_q   [5];
  logic [31:0] it1_x2_q  [5];
  logic        it1_neg_q [5];

  logic [31:0] it2_qe_q  [5];
  logic [31:0] it2_a_q   [5];
  logic [30:0] it2_x_q   [5];
  logic [31:0] it2_x2_q  [5];
  logic        it2_neg_q [5];

  logic [30:0] it3_t_q   [5];
  logic [30:0] it3_x_q   [5];
  logic [31:0] it3_x2_q  [5];
  logic        it3_neg_q [5];

  for (genvar k = 0; k < 5; k++) begin : g_step
    logic [62:0] prod1;
    logic [32:0] pr1;
    logic [69:0] prod2;
    logic [31:0] rem3;
    logic [31:0] q3;

    if (k == 0) begin : g_first
      assign it_t_in[k]   = Q30_ONE;
      assign it_x_in[k]   = x_e_q;
      assign it_x2_in[k]  = x2_e_q;
      assign it_neg_in[k] = neg_e_q;
    end else begin : g_next
      assign it_t_in[k]   = it3_t_q[k-1];
      assign it_x_in[k]   = it3_x_q[k-1];
      assign it_x2_in[k]  = it3_x2_q[k-1];
      assign it_neg_in[k] = it3_neg_q[k-1];
    end

    assign prod1 = 63'(it_x2_in[k]) * 63'(it_t_in[k]);
    assign pr1   = prod1[62:30] >> SER_SHIFT[k];
    assign prod2 = 70'(it1_a_q[k]) * 70'(SER_RECIP[k]);
    assign rem3  = it2_a_q[k] - 32'(38'(it2_qe_q[k]) * 38'(SER_ODD[k]));
    assign q3    = (rem3 >= 32'(SER_ODD[k])) ? it2_qe_q[k] + 32'd1 : it2_qe_q[k];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        it1_a_q[k]   <= 32'(pr1);
        it1_x_q[k]   <= it_x_in[k];
        it1_x2_q[k]  <= it_x2_in[k];
        it1_neg_q[k] <= it_neg_in[k];

        it2_qe_q[k]  <= prod2[69:38];
        it2_a_q[k]   <= it1_a_q[k];
        it2_x_q[k]   <= it1_x_q[k];
        it2_x2_q[k]  <= it1_x2_q[k];
        it2_neg_q[k] <= it1_neg_q[k];

        it3_t_q[k]   <= Q30_ONE - 31'(q3);
        it3_x_q[k]   <= it2_x_q[k];
        it3_x2_q[k]  <= it2_x2_q[k];
        it3_neg_q[k] <= it2_neg_q[k];
      end
    end
  end

  // Final stage: x times the series, clamped to one.
  logic [61:0] prod_f;

  assign prod_f = 62'(it3_x_q[4]) * 62'(it3_t_q[4]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_o <= (prod_f[61:30] > 32'(Q30_ONE)) ? Q30_ONE : prod_f[60:30];
      neg_o <= it3_neg_q[4];
    end
  end

endmodule

// ----- hw/rtl/uv_sphere_vertex_generator.sv -----
// Throughput: one grid point per cycle unless a valid output is stalled; the 28 register
// stages, mostly the four sine lanes with their five-step series, advance together and
// all hold while a valid output is stalled.
// Reset clears every stage valid bit and sets num_slices 64, sphere_radius 256 (1.0),
// fov_degrees 360; num_slices and fov_degrees writes also pass a derived-config register.
`timescale 1ns / 1ps

module uv_sphere_vertex_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [6:0]         grid_row_i,
  input  logic [7:0]         grid_col_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic signed [16:0] pos_z_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic [13:0]        vertex_index_o,
  output logic               quad_valid_o,
  output logic [13:0]        corner_below_o,
  output logic [13:0]        corner_diag_o,
  output logic [13:0]        corner_right_o,
  output logic [13:0]        vertex_total_o,
  output logic [15:0]        index_total_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import uvsg_pkg::*;

  typedef enum logic [1:0] {
    CFG_NUM_SLICES    = 2'd0,
    CFG_SPHERE_RADIUS = 2'd1,
    CFG_FOV_DEGREES   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [13:0] vertex_index;
    logic [13:0] corner_below;
    logic [13:0] corner_diag;
    logic [13:0] corner_right;
    logic        quad_valid;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } aux_t;

  localparam int unsigned DEPTH   = 4 + SINE_LAT + 3;
  localparam int unsigned AUX_LEN = SINE_LAT + 4;

  // Pipeline control: every stage moves unless the output holds a stalled result.
  logic             adv;
  logic [DEPTH-1:0] vld_q;

  assign adv         = !(vld_q[DEPTH-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[DEPTH-1];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // Configuration registers.
  logic [7:0]  num_slices_q;
  logic [15:0] sphere_radius_q;
  logic [8:0]  fov_degrees_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_slices_q    <= 8'd64;
      sphere_radius_q <= 16'd256;
      fov_degrees_q   <= 9'd360;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_NUM_SLICES:    num_slices_q    <= cfg_data_i[7:0];
        CFG_SPHERE_RADIUS: sphere_radius_q <= cfg_data_i;
        CFG_FOV_DEGREES:   fov_degrees_q   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Constant tables indexed by a divisor: reciprocal and the split of HALF_PI / n.
  logic [30:0] recip_tab [0:MAX_SLICES];
  logic [30:0] hq_tab    [0:MAX_SLICES];
  logic [6:0]  hr_tab    [0:MAX_SLICES];

  for (genvar Gd = 0; Gd <= MAX_SLICES; Gd++) begin : g_tab
    if (Gd == 0) begin : g_zero
      assign recip_tab[Gd] = '0;
      assign hq_tab[Gd]    = '0;
      assign hr_tab[Gd]    = '0;
    end else begin : g_div
      localparam longint unsigned Recip = (64'd1 << 30) / Gd;
      localparam longint unsigned Hq    = 64'(HALF_PI_Q30) / Gd;
      localparam longint unsigned Hr    = 64'(HALF_PI_Q30) - Gd * Hq;
      assign recip_tab[Gd] = 31'(Recip);
      assign hq_tab[Gd]    = 31'(Hq);
      assign hr_tab[Gd]    = 7'(Hr);
    end
  end

  // Derived configuration, registered from the configuration registers without an enable.
  logic [7:0]  n_c;
  logic [6:0]  p_c;
  logic [7:0]  w_c;
  logic [8:0]  fov_c;
  sine_cfg_t   sine_cfg_q;
  logic [7:0]  n_q;
  logic [6:0]  p_q;
  logic [7:0]  w_q;
  logic [9:0]  n2_q, n3_q, n4_q;
  logic [14:0] pf_q;
  logic [30:0] recip_p_q;
  logic [13:0] vt_q;
  logic [15:0] it_q;

  always_comb begin
    if (num_slices_q < 8'd2) begin
      n_c = 8'd2;
    end else if (num_slices_q > 8'(MAX_SLICES)) begin
      n_c = 8'(MAX_SLICES);
    end else begin
      n_c = num_slices_q;
    end
    p_c   = 7'(n_c >> 1);
    w_c   = n_c + 8'd1;
    fov_c = (fov_degrees_q > 9'd360) ? 9'd360 : fov_degrees_q;
  end

  always_ff @(posedge clk_i) begin
    sine_cfg_q.n     <= n_c;
    sine_cfg_q.recip <= recip_tab[n_c];
    sine_cfg_q.hq    <= hq_tab[n_c];
    sine_cfg_q.hr    <= hr_tab[n_c];
    n_q              <= n_c;
    p_q              <= p_c;
    w_q              <= w_c;
    n2_q             <= 10'(n_c) << 1;
    n3_q             <= 10'(n_c) + (10'(n_c) << 1);
    n4_q             <= 10'(n_c) << 2;
    pf_q             <= 15'(16'(p_c) * 16'(fov_c));
    recip_p_q        <= recip_tab[{1'b0, p_c}];
    vt_q             <= 14'(32'(p_c + 7'd1) * 32'(w_c));
    it_q             <= 16'(32'(p_c) * 32'(n_c) * 32'd6);
  end

  assign vertex_total_o = vt_q;
  assign index_total_o  = it_q;

  // Stage 1: capture the grid point.
  logic [6:0] row1_q;
  logic [7:0] col1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      row1_q <= grid_row_i;
      col1_q <= grid_col_i;
    end
  end

  // Stage 2: quotient estimates for row mod n and col mod n, index and texture terms.
  logic [37:0] qr_prod;
  logic [38:0] qc_prod;
  logic [7:0]  qr2_q, qc2_q;
  logic [6:0]  row2_q;
  logic [7:0]  col2_q;
  logic [13:0] rw2_q;
  logic [15:0] r360_2_q;
  logic [22:0] ua2_q;
  logic [21:0] va2_q;
  logic        colltn2_q, rowltp2_q;

  assign qr_prod = 38'(row1_q) * 38'(sine_cfg_q.recip);
  assign qc_prod = 39'(col1_q) * 39'(sine_cfg_q.recip);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qr2_q     <= qr_prod[37:30];
      qc2_q     <= qc_prod[37:30];
      row2_q    <= row1_q;
      col2_q    <= col1_q;
      rw2_q     <= 14'(16'(row1_q) * 16'(w_q));
      r360_2_q  <= 16'(row1_q) * 16'd360;
      ua2_q     <= {col1_q[6:0], 16'd0} + 23'(n_q >> 1);
      va2_q     <= {row1_q[5:0], 16'd0} + 22'(p_q >> 1);
      colltn2_q <= (col1_q < n_q);
      rowltp2_q <= (row1_q < p_q);
    end
  end

  // Stage 3: finish the reductions, texture quotient estimates.
  logic [15:0] rt_row, rt_col, rr_full, rc_full;
  logic [53:0] qu_prod;
  logic [52:0] qv_prod;
  logic [6:0]  rr3_q, rc3_q;
  logic [13:0] vi3_q;
  logic        qv3_q;
  logic [16:0] que3_q, qve3_q;
  logic [22:0] ua3_q;
  logic [21:0] va3_q;
  logic        colltn3_q, rowltp3_q;

  assign rt_row  = 16'(row2_q) - 16'(qr2_q) * 16'(n_q);
  assign rt_col  = 16'(col2_q) - 16'(qc2_q) * 16'(n_q);
  assign rr_full = (rt_row >= 16'(n_q)) ? rt_row - 16'(n_q) : rt_row;
  assign rc_full = (rt_col >= 16'(n_q)) ? rt_col - 16'(n_q) : rt_col;
  assign qu_prod = 54'(ua2_q) * 54'(sine_cfg_q.recip);
  assign qv_prod = 53'(va2_q) * 53'(recip_p_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rr3_q     <= rr_full[6:0];
      rc3_q     <= rc_full[6:0];
      vi3_q     <= 14'(15'(rw2_q) + 15'(col2_q));
      qv3_q     <= colltn2_q && (r360_2_q < 16'(pf_q));
      que3_q    <= qu_prod[46:30];
      qve3_q    <= qv_prod[46:30];
      ua3_q     <= ua2_q;
      va3_q     <= va2_q;
      colltn3_q <= colltn2_q;
      rowltp3_q <= rowltp2_q;
    end
  end

  // Stage 4: quadrant and in-quadrant remainder per sine lane; index and texture results.
  // Lanes: sin(row), cos(row), sin(col), cos(col).
  logic [9:0]  lane_idx  [4];
  logic [1:0]  lane_quad [4];
  logic [6:0]  lane_rem  [4];
  logic [9:0]  idx_rc_raw, idx_cc_raw;
  logic [24:0] ru;
  logic [23:0] rv;
  logic [16:0] qu, qv;
  aux_t        aux_d;

  always_comb begin
    idx_rc_raw  = {1'b0, rr3_q, 2'b00} + 10'(n_q);
    idx_cc_raw  = {1'b0, rc3_q, 2'b00} + 10'(n_q);
    lane_idx[0] = {1'b0, rr3_q, 2'b00};
    lane_idx[1] = (idx_rc_raw >= n4_q) ? idx_rc_raw - n4_q : idx_rc_raw;
    lane_idx[2] = {1'b0, rc3_q, 2'b00};
    lane_idx[3] = (idx_cc_raw >= n4_q) ? idx_cc_raw - n4_q : idx_cc_raw;
    for (int l = 0; l < 4; l++) begin
      if (lane_idx[l] >= n3_q) begin
        lane_quad[l] = 2'd3;
        lane_rem[l]  = 7'(lane_idx[l] - n3_q);
      end else if (lane_idx[l] >= n2_q) begin
        lane_quad[l] = 2'd2;
        lane_rem[l]  = 7'(lane_idx[l] - n2_q);
      end else if (lane_idx[l] >= 10'(n_q)) begin
        lane_quad[l] = 2'd1;
        lane_rem[l]  = 7'(lane_idx[l] - 10'(n_q));
      end else begin
        lane_quad[l] = 2'd0;
        lane_rem[l]  = lane_idx[l][6:0];
      end
    end

    ru = 25'(ua3_q) - 25'(que3_q) * 25'(n_q);
    rv = 24'(va3_q) - 24'(qve3_q) * 24'(p_q);
    qu = (ru >= 25'(n_q)) ? que3_q + 17'd1 : que3_q;
    qv = (rv >= 24'(p_q)) ? qve3_q + 17'd1 : qve3_q;

    aux_d.vertex_index = vi3_q;
    aux_d.corner_below = vi3_q + 14'(w_q);
    aux_d.corner_diag  = vi3_q + 14'(w_q) + 14'd1;
    aux_d.corner_right = vi3_q + 14'd1;
    aux_d.quad_valid   = qv3_q;
    aux_d.tex_u        = colltn3_q ? qu : 17'h10000;
    aux_d.tex_v        = rowltp3_q ? 17'h10000 - qv : 17'd0;
  end

  logic [1:0] lane_quad_q [4];
  logic [6:0] lane_rem_q  [4];
  aux_t       aux_q [AUX_LEN];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        lane_quad_q[l] <= lane_quad[l];
        lane_rem_q[l]  <= lane_rem[l];
      end
      aux_q[0] <= aux_d;
      for (int i = 1; i < AUX_LEN; i++) begin
        aux_q[i] <= aux_q[i-1];
      end
    end
  end

  // Four sine lanes.
  logic [30:0] sin_mag [4];
  logic        sin_neg [4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    uvsg_sine u_sine (
      .clk_i  (clk_i),
      .en_i   (adv),
      .cfg_i  (sine_cfg_q),
      .quad_i (lane_quad_q[l]),
      .rem_i  (lane_rem_q[l]),
      .mag_o  (sin_mag[l]),
      .neg_o  (sin_neg[l])
    );
  end

  // Product stage 1: r*|sin(row)| to Q8.24 and the rounded y coordinate.
  logic [46:0] mr_prod;
  logic [46:0] y_prod;
  logic [31:0] m_p1_q;
  logic [16:0] y_p1_q;
  logic [30:0] sc_p1_q, cc_p1_q;
  logic        nx_p1_q, ny_p1_q, nz_p1_q;

  assign mr_prod = 47'(sphere_radius_q) * 47'(sin_mag[0]);
  assign y_prod  = 47'(sphere_radius_q) * 47'(sin_mag[1]) + (47'd1 << 29);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_p1_q  <= mr_prod[45:14];
      y_p1_q  <= y_prod[46:30];
      sc_p1_q <= sin_mag[2];
      cc_p1_q <= sin_mag[3];
      nx_p1_q <= sin_neg[0] ^ sin_neg[2];
      nz_p1_q <= sin_neg[0] ^ sin_neg[3];
      ny_p1_q <= sin_neg[1];
    end
  end

  // Product stage 2: times |sin(col)| and |cos(col)|, rounded half up to Q8.8.
  logic [62:0] px_prod, pz_prod;
  logic [16:0] px_p2_q, pz_p2_q, y_p2_q;
  logic        nx_p2_q, ny_p2_q, nz_p2_q;

  assign px_prod = 63'(m_p1_q) * 63'(sc_p1_q) + (63'd1 << 45);
  assign pz_prod = 63'(m_p1_q) * 63'(cc_p1_q) + (63'd1 << 45);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_p2_q <= px_prod[62:46];
      pz_p2_q <= pz_prod[62:46];
      y_p2_q  <= y_p1_q;
      nx_p2_q <= nx_p1_q;
      ny_p2_q <= ny_p1_q;
      nz_p2_q <= nz_p1_q;
    end
  end

  // Output stage: apply signs.
  logic [16:0] pos_x_q, pos_y_q, pos_z_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_x_q <= nx_p2_q ? 17'd0 - px_p2_q : px_p2_q;
      pos_y_q <= ny_p2_q ? 17'd0 - y_p2_q : y_p2_q;
      pos_z_q <= nz_p2_q ? 17'd0 - pz_p2_q : pz_p2_q;
    end
  end

  assign pos_x_o        = signed'(pos_x_q);
  assign pos_y_o        = signed'(pos_y_q);
  assign pos_z_o        = signed'(pos_z_q);
  assign tex_u_o        = aux_q[AUX_LEN-1].tex_u;
  assign tex_v_o        = aux_q[AUX_LEN-1].tex_v;
  assign vertex_index_o = aux_q[AUX_LEN-1].vertex_index;
  assign quad_valid_o   = aux_q[AUX_LEN-1].quad_valid;
  assign corner_below_o = aux_q[AUX_LEN-1].corner_below;
  assign corner_diag_o  = aux_q[AUX_LEN-1].corner_diag;
  assign corner_right_o = aux_q[AUX_LEN-1].corner_right;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import uvsg_pkg::*;

  localparam int unsigned CFG_SLICES = 0;
  localparam int unsigned CFG_RADIUS = 1;
  localparam int unsigned CFG_FOV    = 2;

  typedef enum int unsigned {
    IDLE_SENDER_LIGHT,
    IDLE_SENDER_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  typedef struct packed {
    logic [6:0] row;
    logic [7:0] col;
  } grid_point_t;

  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [13:0]        vertex_index;
    logic               quad_valid;
    logic [13:0]        corner_below;
    logic [13:0]        corner_diag;
    logic [13:0]        corner_right;
    logic [13:0]        vertex_total;
    logic [15:0]        index_total;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [6:0] grid_row_i = '0;
  logic [7:0] grid_col_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [16:0] pos_x_o, pos_y_o, pos_z_o;
  logic [16:0] tex_u_o, tex_v_o;
  logic [13:0] vertex_index_o, corner_below_o, corner_diag_o, corner_right_o, vertex_total_o;
  logic quad_valid_o;
  logic [15:0] index_total_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  // Local copy of the configuration registers.
  int unsigned slices_reg = 64;
  int unsigned radius_reg = 256;
  int unsigned fov_reg = 360;

  grid_point_t pending_points[$];
  vertex_t     expected_vertices[$];
  idle_mode_e  idle_mode = IDLE_SENDER_LIGHT;
  int unsigned mismatch_count = 0;

  always #2 clk_i = ~clk_i;

  uv_sphere_vertex_generator u_dut (.*);

  // Odd Taylor series of the sine in Q30, Horner form with truncation.
  function automatic longint unsigned sine_series(longint unsigned x);
    longint unsigned divs[5] = '{110, 72, 42, 20, 6};
    longint unsigned x2, t;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    for (int i = 0; i < 5; i++) t = Q30_ONE - ((x2 * t) >> 30) / divs[i];
    t = (x * t) >> 30;
    return (t > Q30_ONE) ? longint'(Q30_ONE) : t;
  endfunction

  // Sine of num4/(4n) of a full turn, signed Q30.
  function automatic longint sine_of_quarters(int unsigned num4, int unsigned n);
    int unsigned quad, rem;
    longint unsigned x, v;
    num4 = num4 % (4 * n);
    quad = num4 / n;
    rem = num4 - quad * n;
    x = longint'(rem) * HALF_PI_Q30 / n;
    if (quad[0]) x = HALF_PI_Q30 - x;
    v = sine_series(x);
    return (quad >= 2) ? -longint'(v) : longint'(v);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic [16:0] scaled_product(int unsigned r, longint s1, longint s2);
    longint unsigned m, p;
    m = (longint'(r) * magnitude(s1)) >> 14;
    p = (m * magnitude(s2) + (64'd1 << 45)) >> 46;
    return ((s1 < 0) != (s2 < 0)) ? 17'(-p) : 17'(p);
  endfunction

  // Computes the vertex record for one grid point under the current registers.
  function automatic vertex_t vertex_of(grid_point_t pt);
    vertex_t vx;
    int unsigned n, p, w, fov, row, col;
    longint sr, cr, sc, cc;
    longint unsigned y;
    row = pt.row;
    col = pt.col;
    n = slices_reg;
    if (n > MAX_SLICES) n = MAX_SLICES;
    if (n < 2) n = 2;
    p = n / 2;
    w = n + 1;
    fov = (fov_reg > 360) ? 360 : fov_reg;
    sr = sine_of_quarters(4 * row, n);
    cr = sine_of_quarters(4 * row + n, n);
    sc = sine_of_quarters(4 * col, n);
    cc = sine_of_quarters(4 * col + n, n);
    vx.pos_x = scaled_product(radius_reg, sr, sc);
    y = (longint'(radius_reg) * magnitude(cr) + (64'd1 << 29)) >> 30;
    vx.pos_y = (cr < 0) ? 17'(-y) : 17'(y);
    vx.pos_z = scaled_product(radius_reg, sr, cc);
    vx.tex_u = (col >= n) ? 17'd65536 : 17'((col * 65536 + n / 2) / n);
    vx.tex_v = (row >= p) ? 17'd0 : 17'(65536 - (row * 65536 + p / 2) / p);
    vx.vertex_index = 14'(row * w + col);
    vx.quad_valid = (col < n && row * 360 < p * fov);
    vx.corner_below = 14'((row + 1) * w + col);
    vx.corner_diag = 14'((row + 1) * w + col + 1);
    vx.corner_right = 14'(row * w + col + 1);
    vx.vertex_total = 14'((p + 1) * w);
    vx.index_total = 16'(p * n * 6);
    return vx;
  endfunction

  function automatic bit roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Driver: presents queued grid points, idling at random.
  always @(posedge clk_i) begin
    if (!in_valid_i || !in_stall_o) begin
      if (pending_points.size() > 0 &&
          !(idle_mode == IDLE_SENDER_LIGHT && roll(19)) &&
          !(idle_mode == IDLE_SENDER_HEAVY && roll(45))) begin
        grid_point_t pt;
        pt = pending_points.pop_front();
        grid_row_i <= pt.row;
        grid_col_i <= pt.col;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    case (idle_mode)
      IDLE_SENDER_LIGHT: begin
        out_stall_i <= roll(45);
      end
      IDLE_SENDER_HEAVY: begin
        out_stall_i <= roll(19);
      end
      default: begin
        out_stall_i <= 1'b0;
      end
    endcase
  end

  // Monitor: predicts on accepted inputs and checks accepted outputs.
  always @(posedge clk_i) begin
    vertex_t got;
    vertex_t exp_vx;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_vertices.push_back(vertex_of('{row: grid_row_i, col: grid_col_i}));
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{pos_x_o, pos_y_o, pos_z_o, tex_u_o, tex_v_o, vertex_index_o, quad_valid_o,
                corner_below_o, corner_diag_o, corner_right_o, vertex_total_o, index_total_o};
        if (expected_vertices.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Unexpected output transaction: %p", got);
        end else begin
          exp_vx = expected_vertices.pop_front();
          if (got !== exp_vx) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Mismatch: expected %p", exp_vx);
              $display("          actual   %p", got);
            end
          end
        end
      end
    end
  end

  task automatic write_register(int unsigned idx, int unsigned value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= 2'(idx);
    cfg_data_i <= 16'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SLICES: slices_reg = value & 8'hFF;
      CFG_RADIUS: radius_reg = value & 16'hFFFF;
      default: fov_reg = value & 9'h1FF;
    endcase
  endtask

  task automatic queue_random_points(int unsigned count);
    int unsigned n;
    n = (slices_reg > MAX_SLICES) ? MAX_SLICES : ((slices_reg < 2) ? 2 : slices_reg);
    repeat (count) begin
      if (roll(75)) begin
        pending_points.push_back('{row: 7'($urandom_range(0, n / 2)),
                                   col: 8'($urandom_range(0, n))});
      end else begin
        pending_points.push_back('{row: 7'($urandom_range(0, 127)),
                                   col: 8'($urandom_range(0, 255))});
      end
    end
  endtask

  // Waits until every presented point is accepted and its result has come,
  // then past the pipeline depth.
  task automatic drain();
    wait (pending_points.size() == 0 && !in_valid_i && expected_vertices.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  // Stimulus: directed points at reset settings, then random phases over settings.
  initial begin
    int unsigned slices_set[9] = '{64, 2, 128, 255, 1, 0, 7, 33, 100};
    int unsigned radius_set[9] = '{256, 65535, 0, 65535, 12345, 300, 40000, 1, 777};
    int unsigned fov_set[9] = '{360, 0, 360, 511, 90, 200, 359, 180, 45};
    grid_point_t directed[$] = '{
      '{0, 0}, '{32, 64}, '{127, 255}, '{0, 64}, '{32, 0}, '{16, 16}, '{31, 63},
      '{64, 128}, '{1, 1}, '{96, 200}, '{8, 48}, '{24, 32}, '{33, 65}, '{0, 128},
      '{127, 0}, '{16, 0}, '{15, 63}, '{85, 170}, '{42, 85}, '{31, 64}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    pending_points = directed;
    drain();
    for (int ph = 0; ph < 9; ph++) begin
      idle_mode = (ph < 3) ? IDLE_SENDER_LIGHT : ((ph < 6) ? IDLE_SENDER_HEAVY : IDLE_NONE);
      write_register(CFG_SLICES, slices_set[ph]);
      write_register(CFG_RADIUS, radius_set[ph]);
      write_register(CFG_FOV, fov_set[ph]);
      queue_random_points(145);
      drain();
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
